>>> rtl/skf_pkg.sv
`default_nettype none

package skf_pkg;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 17;
  localparam int Q_FRAC     = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 33;
  localparam int DIV_STEPS  = 17;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(1 << Q_FRAC);

  localparam logic [DATA_W-1:0] MEAS_NOISE_RST = 32'd65536;
  localparam logic [DATA_W-1:0] INIT_NOISE_RST = 32'd65536;
  localparam logic [DATA_W-1:0] PROC_NOISE_RST = 32'd655;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MEAS_NOISE = 2'd0,
    CFG_INIT_NOISE = 2'd1,
    CFG_PROC_NOISE = 2'd2
  } cfg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_MSTEP = 7'b0000100,
    ST_MERR  = 7'b0001000,
    ST_MQLO  = 7'b0010000,
    ST_MQHI  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/skf_mul.sv
`default_nettype none

module skf_mul
  import skf_pkg::*;
#(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0]    p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end
  end

endmodule

`default_nettype wire

>>> rtl/scalar_kalman_filter_core.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | measurement
// out      | out_valid / out_ready| filtered_estimate, gain_used, updated_error
// cfg      | cfg_write            | cfg_addr, cfg_data
//
// Per item: accept, 17 restoring-division steps for the gain, 4 passes through the
// shared 17x33 multiplier, then forming and registering the result.
// in_ready is high only while the sequencer is idle; a result waiting in the output
// register does not block the next transaction until that next result is finished.
// rst is synchronous: control, config and estimate registers reset, error to 1.0.
`default_nettype none

module scalar_kalman_filter_core
  import skf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] measurement,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      filtered_estimate,
  output logic [GAIN_W-1:0]             gain_used,
  output logic [DATA_W-1:0]             updated_error,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [DATA_W-1:0]        cfg_data
);

  state_t state;

  logic [DATA_W-1:0] meas_noise;
  logic [DATA_W-1:0] proc_noise;
  logic [DATA_W-1:0] prev_est;
  logic [DATA_W-1:0] est_err;

  logic [DATA_W:0]   den;
  logic              den_zero;
  logic [DATA_W:0]   rem;
  logic [GAIN_W-1:0] quot;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   dmag;
  logic              dneg;
  logic [DATA_W:0]   step;
  logic [DATA_W-1:0] err1;
  logic [DATA_W:0]   plo;

  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic                       mul_en;
  logic [MUL_A_W+MUL_B_W-1:0] prod;

  logic              in_fire;
  logic              fin_fire;
  logic [DATA_W:0]   d;
  logic [DATA_W+1:0] rem_sh;
  logic [DATA_W+2:0] diff;
  logic              ge;
  logic [GAIN_W-1:0] gain;
  logic [49:0]       add;
  logic [50:0]       err_sum;
  logic [DATA_W-1:0] err_sat;
  logic [DATA_W-1:0] x_new;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fin_fire = (state == ST_FIN) && (!out_valid || out_ready);

  assign d = {measurement[DATA_W-1], measurement} - {prev_est[DATA_W-1], prev_est};

  assign rem_sh = {rem, (cnt == '0) ? est_err[0] : 1'b0};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};
  assign ge     = !diff[DATA_W+2];
  assign gain   = den_zero ? '0 : quot;

  assign add     = 50'(prod[48:0]) + 50'(plo);
  assign err_sum = 51'(add) + 51'(err1);
  assign err_sat = (err_sum[50:DATA_W] != '0) ? '1 : err_sum[DATA_W-1:0];
  assign x_new   = dneg ? prev_est - step[DATA_W-1:0] : prev_est + step[DATA_W-1:0];

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_MSTEP: begin
        mul_en = 1'b1;
        mul_a  = gain;
        mul_b  = dmag;
      end
      ST_MERR: begin
        mul_en = 1'b1;
        mul_a  = ONE_Q16 - gain;
        mul_b  = {1'b0, est_err};
      end
      ST_MQLO: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, proc_noise[15:0]};
        mul_b  = step;
      end
      ST_MQHI: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, proc_noise[31:16]};
        mul_b  = step;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  skf_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      out_valid  <= 1'b0;
      meas_noise <= MEAS_NOISE_RST;
      proc_noise <= PROC_NOISE_RST;
      prev_est   <= '0;
      est_err    <= INIT_NOISE_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_addr)
          CFG_MEAS_NOISE: meas_noise <= cfg_data;
          CFG_INIT_NOISE: est_err    <= cfg_data;
          CFG_PROC_NOISE: proc_noise <= cfg_data;
          default: ;
        endcase
      end
      if (fin_fire) begin
        out_valid <= 1'b1;
        prev_est  <= x_new;
        est_err   <= err_sat;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_DIV;
            cnt   <= '0;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_MSTEP;
          end
          cnt <= cnt + 1'b1;
        end
        ST_MSTEP: state <= ST_MERR;
        ST_MERR:  state <= ST_MQLO;
        ST_MQLO:  state <= ST_MQHI;
        ST_MQHI:  state <= ST_FIN;
        ST_FIN: begin
          if (fin_fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      den      <= {1'b0, est_err} + {1'b0, meas_noise};
      den_zero <= (est_err == '0) && (meas_noise == '0);
      rem      <= {2'b00, est_err[DATA_W-1:1]};
      quot     <= '0;
      dneg     <= d[DATA_W];
      dmag     <= d[DATA_W] ? (~d + 1'b1) : d;
    end
    if (state == ST_DIV) begin
      rem  <= ge ? diff[DATA_W:0] : rem_sh[DATA_W:0];
      quot <= {quot[GAIN_W-2:0], ge};
    end
    if (state == ST_MERR) begin
      step <= prod[48:16];
    end
    if (state == ST_MQLO) begin
      err1 <= prod[47:16];
    end
    if (state == ST_MQHI) begin
      plo <= prod[48:16];
    end
    if (fin_fire) begin
      filtered_estimate <= x_new;
      gain_used         <= gain;
      updated_error     <= err_sat;
    end
  end

endmodule

`default_nettype wire

>>> rtl/skf_checker.sv
`default_nettype none

module skf_checker
  import skf_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DATA_W-1:0] filtered_estimate,
  input wire logic [GAIN_W-1:0]        gain_used,
  input wire logic [DATA_W-1:0]        updated_error
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous transaction still in progress");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain_used <= ONE_Q16)
    else $error("gain above 1.0");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_estimate)
      && $stable(gain_used) && $stable(updated_error))
    else $error("stalled result changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear the result channel");

endmodule

bind scalar_kalman_filter_core skf_checker u_skf_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .filtered_estimate (filtered_estimate),
  .gain_used         (gain_used),
  .updated_error     (updated_error)
);

`default_nettype wire
